>>> src/fql_pkg.sv
// Shared types and codes for the FIFO-queued hardware lock.
package fql_pkg;

  // Request function codes
  localparam logic [1:0] FN_TRY    = 2'd0;
  localparam logic [1:0] FN_LOCK   = 2'd1;
  localparam logic [1:0] FN_UNLOCK = 2'd2;

  // Response status codes
  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_QUEUED  = 3'd2;
  localparam logic [2:0] ST_FREED   = 3'd3;
  localparam logic [2:0] ST_HANDED  = 3'd4;
  localparam logic [2:0] ST_ERROR   = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] thread_id;
  } lk_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  granted_thread;
    logic [31:0] lock_count;
    logic [31:0] contention_count;
  } lk_rsp_t;

  // One per-thread record: wait link plus both counters
  typedef struct packed {
    logic        wait_vld;
    logic [3:0]  wait_pred;
    logic [31:0] locks;
    logic [31:0] conts;
  } lk_entry_t;

  localparam int ENT_W = $bits(lk_entry_t);

endpackage

>>> src/fql_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fql_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/fifo_queued_lock.sv
// Top level: FIFO-queued mutex, per-thread state held in one RAM.
// Flow: a request is accepted in S_IDLE, resolved in S_REQ from the registered
//   table read and answered from S_DONE; an unlock that hands the lock to a
//   waiter reads one wait-list link per S_WALK step (up to NUM_THREADS links),
//   paced by the single RAM read port; no new request is taken until S_IDLE.
// Reset: control state clears synchronously; per-thread entries read as zero
//   until first written, tracked by one valid flop per thread.
module fifo_queued_lock #(
  parameter int NUM_THREADS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  fql_pkg::lk_req_t req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output fql_pkg::lk_rsp_t rsp
);

  localparam int AW = $clog2(NUM_THREADS);

  typedef enum logic [1:0] {S_IDLE, S_REQ, S_WALK, S_DONE} state_t;

  state_t                state, state_next;
  logic                  held, held_next;
  logic [3:0]            owner, owner_next;
  logic [3:0]            newest, newest_next;
  logic [3:0]            cur, cur_next;
  logic [AW-1:0]         walk_cnt, walk_cnt_next;
  logic [1:0]            func_r, func_r_next;
  logic [3:0]            tid_r, tid_r_next;
  logic [31:0]           cont_t, cont_t_next;
  fql_pkg::lk_rsp_t      res, res_next;
  fql_pkg::lk_rsp_t      rsp_next;
  logic                  rsp_valid_next;
  logic [NUM_THREADS-1:0] ent_vld;
  logic                  rd_vld;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  fql_pkg::lk_entry_t    ram_wdata;
  logic [fql_pkg::ENT_W-1:0] ram_rdata;
  fql_pkg::lk_entry_t    ent;
  logic                  tid_ok, pred_ok, newest_ok;

  fql_ram #(
    .WIDTH (fql_pkg::ENT_W),
    .DEPTH (NUM_THREADS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero
  assign ent       = rd_vld ? fql_pkg::lk_entry_t'(ram_rdata) : '0;
  assign tid_ok    = (32'(tid_r) < 32'(NUM_THREADS));
  assign pred_ok   = (32'(ent.wait_pred) < 32'(NUM_THREADS));
  assign newest_ok = (32'(newest) < 32'(NUM_THREADS));
  assign req_stall = (state != S_IDLE);

  // request sequencing and read-modify-write of the thread table
  always_comb begin
    state_next     = state;
    held_next      = held;
    owner_next     = owner;
    newest_next    = newest;
    cur_next       = cur;
    walk_cnt_next  = walk_cnt;
    func_r_next    = func_r;
    tid_r_next     = tid_r;
    cont_t_next    = cont_t;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    ram_we         = 1'b0;
    ram_waddr      = AW'(tid_r);
    ram_wdata      = ent;
    ram_raddr      = AW'(req.thread_id);

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          func_r_next = req.func;
          tid_r_next  = req.thread_id;
          state_next  = S_REQ;
        end
      end

      S_REQ: begin
        res_next.status           = fql_pkg::ST_ERROR;
        res_next.granted_thread   = '0;
        res_next.lock_count       = '0;
        res_next.contention_count = tid_ok ? ent.conts : '0;
        state_next                = S_DONE;
        if (tid_ok) begin
          unique case (func_r)
            fql_pkg::FN_TRY, fql_pkg::FN_LOCK: begin
              if (!held) begin
                // free: grant to requester
                ram_we                  = 1'b1;
                ram_wdata.wait_vld      = 1'b0;
                ram_wdata.wait_pred     = '0;
                ram_wdata.locks         = ent.locks + 32'd1;
                held_next               = 1'b1;
                owner_next              = tid_r;
                newest_next             = tid_r;
                res_next.status         = fql_pkg::ST_GRANTED;
                res_next.granted_thread = tid_r;
                res_next.lock_count     = ent.locks + 32'd1;
              end else if (tid_r == owner || ent.wait_vld) begin
                res_next.status = fql_pkg::ST_ERROR;
              end else if (func_r == fql_pkg::FN_TRY) begin
                res_next.status = fql_pkg::ST_BUSY;
              end else begin
                // held: link behind newest waiter
                ram_we                    = 1'b1;
                ram_wdata.wait_vld        = 1'b1;
                ram_wdata.wait_pred       = newest;
                ram_wdata.conts           = ent.conts + 32'd1;
                newest_next               = tid_r;
                res_next.status           = fql_pkg::ST_QUEUED;
                res_next.contention_count = ent.conts + 32'd1;
              end
            end
            fql_pkg::FN_UNLOCK: begin
              if (held && tid_r == owner) begin
                if (newest == owner) begin
                  held_next       = 1'b0;
                  res_next.status = fql_pkg::ST_FREED;
                end else if (newest_ok) begin
                  // start walk at newest waiter
                  cont_t_next   = ent.conts;
                  cur_next      = newest;
                  walk_cnt_next = '0;
                  ram_raddr     = AW'(newest);
                  state_next    = S_WALK;
                end
              end
            end
            default: begin
              res_next.status = fql_pkg::ST_ERROR;
            end
          endcase
        end
      end

      S_WALK: begin
        res_next.status           = fql_pkg::ST_ERROR;
        res_next.granted_thread   = '0;
        res_next.lock_count       = '0;
        res_next.contention_count = cont_t;
        state_next                = S_DONE;
        if (ent.wait_vld) begin
          if (ent.wait_pred == owner) begin
            // oldest waiter found: hand over
            ram_we                  = 1'b1;
            ram_waddr               = AW'(cur);
            ram_wdata.wait_vld      = 1'b0;
            ram_wdata.wait_pred     = '0;
            ram_wdata.locks         = ent.locks + 32'd1;
            owner_next              = cur;
            res_next.status         = fql_pkg::ST_HANDED;
            res_next.granted_thread = cur;
            res_next.lock_count     = ent.locks + 32'd1;
          end else if (walk_cnt != AW'(NUM_THREADS - 1) && pred_ok) begin
            // follow link one step back
            cur_next      = ent.wait_pred;
            walk_cnt_next = walk_cnt + 1'b1;
            ram_raddr     = AW'(ent.wait_pred);
            state_next    = S_WALK;
          end
        end
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, table valid flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= 1'b0;
      owner     <= '0;
      newest    <= '0;
      rsp_valid <= 1'b0;
      ent_vld   <= '0;
      rd_vld    <= 1'b0;
    end else begin
      state     <= state_next;
      held      <= held_next;
      owner     <= owner_next;
      newest    <= newest_next;
      rsp_valid <= rsp_valid_next;
      rd_vld    <= (32'(ram_raddr) < 32'(NUM_THREADS)) && ent_vld[ram_raddr];
      if (ram_we) begin
        ent_vld[ram_waddr] <= 1'b1;
      end
    end
    cur      <= cur_next;
    walk_cnt <= walk_cnt_next;
    func_r   <= func_r_next;
    tid_r    <= tid_r_next;
    cont_t   <= cont_t_next;
    res      <= res_next;
    rsp      <= rsp_next;
  end

  // table is only written while a request is being resolved
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_REQ || state == S_WALK))
    else $error("table write outside request processing");

  // a free lock always has its newest-waiter pointer back at the owner
  a_free_no_waiters: assert property (@(posedge clk) disable iff (rst)
    !held |-> (newest == owner))
    else $error("free lock with a nonempty wait list");

  // a handover result matches the lock ownership it reports
  a_handed_owner: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res.status == fql_pkg::ST_HANDED) |->
      (held && owner == res.granted_thread))
    else $error("handover result disagrees with owner");

  // a result appears only after the done state
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !$past(rsp_valid)) |-> ($past(state) == S_DONE))
    else $error("response raised outside done state");

endmodule
